// File: hw/rtl/bedhv_pkg.sv
// Package for the button edge debounce and hold verifier.
// Holds opcodes, register indexes, field widths and the shared structs.
// No dependencies.
`default_nettype none

package bedhv_pkg;

    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int LEVEL_W = 3;
    localparam int BTN_W   = 2;
    localparam int IDX_W   = 2;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_POLL = 1'b1;

    localparam logic [IDX_W-1:0] REG_MIN_HOLD = 2'd0;
    localparam logic [IDX_W-1:0] REG_LOCKOUT  = 2'd1;
    localparam logic [IDX_W-1:0] REG_ACTIVE   = 2'd2;

    localparam logic [CFG_W-1:0]   MIN_HOLD_RST = 16'd20;
    localparam logic [CFG_W-1:0]   LOCKOUT_RST  = 16'd150;
    localparam logic [LEVEL_W-1:0] ACTIVE_RST   = 3'b100;

    typedef struct packed {
        logic [CFG_W-1:0]   min_hold_ms;
        logic [CFG_W-1:0]   lockout_ms;
        logic [LEVEL_W-1:0] active_levels;
    } t_cfg;

    typedef struct packed {
        logic               opcode;
        logic [BTN_W-1:0]   button;
        logic               raw_level;
        logic [LEVEL_W-1:0] poll_levels;
        logic [TIME_W-1:0]  time_ms;
    } t_cmd;

    // Buttons without a bit in a level field read as level 0.
    function automatic logic level_bit(input logic [LEVEL_W-1:0] levels, input int idx);
        logic res;
        res = 1'b0;
        for (int k = 0; k < LEVEL_W; k++) begin
            if (k == idx) begin
                res = levels[k];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/button_edge_debounce_hold_verify.sv
// Top level of the button edge debounce and hold verifier.
// Depends on bedhv_pkg, bedhv_state and bedhv_emit.
//
// Input items enter on i_in_valid / o_in_stall; a transfer happens at a rising
// edge with valid high and stall low. Opcode 0 is a pin edge, opcode 1 a poll.
// Results leave on o_out_valid / i_out_stall, one transfer per decision, with
// o_last_of_run set on the final decision of a poll.
// Every accepted item waits in the input register and is processed there.
// An edge item updates the button state when it is processed and produces no
// result. A poll item loads the result sequencer, so its first result comes
// from the input register through the sequencer's mask register; a poll that
// decides k buttons sends one result per cycle while the receiver does not stall.
// Edges stream at one per cycle unless a poll waits ahead of them. A poll
// waits in the input register while the sequencer still holds results of an
// earlier poll. When the receiver stalls, the current result holds and the
// input side stalls once a poll waits behind it. Reset clears the per-button
// seen and armed flags and pending results and restores the register defaults.
`default_nettype none

module button_edge_debounce_hold_verify #(
    parameter int NUM_BUTTONS = 3
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [bedhv_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire logic [bedhv_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_opcode,
    input  wire logic [bedhv_pkg::BTN_W-1:0]    i_button,
    input  wire logic                           i_raw_level,
    input  wire logic [bedhv_pkg::LEVEL_W-1:0]  i_poll_levels,
    input  wire logic [bedhv_pkg::TIME_W-1:0]   i_time_ms,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [bedhv_pkg::BTN_W-1:0]         o_button_id,
    output logic                                o_accepted,
    output logic [bedhv_pkg::TIME_W-1:0]        o_press_time,
    output logic                                o_last_of_run
);

    bedhv_pkg::t_cfg r_cfg;
    bedhv_pkg::t_cmd r_cmd;
    logic            r_in_valid;

    logic                   in_go;
    logic                   in_load;
    logic                   emit_ready;
    logic                   poll_load;
    logic [NUM_BUTTONS-1:0] due;
    logic [NUM_BUTTONS-1:0] still;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_hold_ms   <= bedhv_pkg::MIN_HOLD_RST;
            r_cfg.lockout_ms    <= bedhv_pkg::LOCKOUT_RST;
            r_cfg.active_levels <= bedhv_pkg::ACTIVE_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                bedhv_pkg::REG_MIN_HOLD: r_cfg.min_hold_ms <= i_cfg_data;
                bedhv_pkg::REG_LOCKOUT:  r_cfg.lockout_ms  <= i_cfg_data;
                bedhv_pkg::REG_ACTIVE:
                    r_cfg.active_levels <= i_cfg_data[bedhv_pkg::LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_go      = r_in_valid &&
                        ((r_cmd.opcode == bedhv_pkg::OP_EDGE) || emit_ready);
    assign o_in_stall = r_in_valid && !in_go;
    assign in_load    = i_in_valid && !o_in_stall;
    assign poll_load  = in_go && (r_cmd.opcode == bedhv_pkg::OP_POLL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (in_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_cmd.opcode      <= i_opcode;
            r_cmd.button      <= i_button;
            r_cmd.raw_level   <= i_raw_level;
            r_cmd.poll_levels <= i_poll_levels;
            r_cmd.time_ms     <= i_time_ms;
        end
    end

    bedhv_state #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (r_cmd),
        .i_cfg   (r_cfg),
        .i_go    (in_go),
        .o_due   (due),
        .o_still (still)
    );

    bedhv_emit #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (poll_load),
        .i_mask        (due),
        .i_still       (still),
        .i_time        (r_cmd.time_ms),
        .o_ready       (emit_ready),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_button_id   (o_button_id),
        .o_accepted    (o_accepted),
        .o_press_time  (o_press_time),
        .o_last_of_run (o_last_of_run)
    );

    // A transfer that is not the last of its poll is always followed by more.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_of_run |=> o_out_valid)
        else $error("result run ended before its last decision");

    // A poll never overwrites results that the receiver has not taken.
    a_poll_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && (r_cmd.opcode == bedhv_pkg::OP_POLL) && o_out_valid &&
        i_out_stall |-> o_in_stall)
        else $error("poll processed while results were pending");

    // Reported buttons exist.
    a_button_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (NUM_BUTTONS > 4) || (32'(o_button_id) < NUM_BUTTONS))
        else $error("result names a button that does not exist");

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

// File: hw/rtl/bedhv_state.sv
// Per-button lockout and candidate state, with the hold-time compare.
// Depends on bedhv_pkg.
`default_nettype none

module bedhv_state #(
    parameter int NUM_BUTTONS = 3
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire bedhv_pkg::t_cmd        i_cmd,
    input  wire bedhv_pkg::t_cfg        i_cfg,
    input  wire logic                   i_go,
    output logic [NUM_BUTTONS-1:0]      o_due,
    output logic [NUM_BUTTONS-1:0]      o_still
);

    logic [bedhv_pkg::TIME_W-1:0] r_last_time [NUM_BUTTONS];
    logic [bedhv_pkg::TIME_W-1:0] r_cand_time [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0]       r_edge_seen;
    logic [NUM_BUTTONS-1:0]       r_armed;

    logic [NUM_BUTTONS-1:0] hit_edge;
    logic [NUM_BUTTONS-1:0] edge_active;
    logic                   edge_go;
    logic                   poll_go;

    assign edge_go = i_go && (i_cmd.opcode == bedhv_pkg::OP_EDGE);
    assign poll_go = i_go && (i_cmd.opcode == bedhv_pkg::OP_POLL);

    always_comb begin
        logic [bedhv_pkg::TIME_W-1:0] lock_diff;
        logic [bedhv_pkg::TIME_W-1:0] hold_diff;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            lock_diff = i_cmd.time_ms - r_last_time[i];
            hold_diff = i_cmd.time_ms - r_cand_time[i];
            hit_edge[i] = edge_go && (32'(i_cmd.button) == i) &&
                          !(r_edge_seen[i] &&
                            (lock_diff < {16'd0, i_cfg.lockout_ms}));
            edge_active[i] = (i_cmd.raw_level ==
                              bedhv_pkg::level_bit(i_cfg.active_levels, i));
            o_due[i] = r_armed[i] && (hold_diff >= {16'd0, i_cfg.min_hold_ms});
            o_still[i] = (bedhv_pkg::level_bit(i_cmd.poll_levels, i) ==
                          bedhv_pkg::level_bit(i_cfg.active_levels, i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_seen <= '0;
            r_armed     <= '0;
        end else begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                if (hit_edge[i]) begin
                    r_edge_seen[i] <= 1'b1;
                    r_armed[i]     <= edge_active[i];
                end else if (poll_go && o_due[i]) begin
                    r_armed[i] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (hit_edge[i]) begin
                r_last_time[i] <= i_cmd.time_ms;
                if (edge_active[i]) begin
                    r_cand_time[i] <= i_cmd.time_ms;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/bedhv_emit.sv
// Result sequencer: sends the decisions of one poll in ascending button order.
// Depends on bedhv_pkg.
`default_nettype none

module bedhv_emit #(
    parameter int NUM_BUTTONS = 3
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_load,
    input  wire logic [NUM_BUTTONS-1:0]         i_mask,
    input  wire logic [NUM_BUTTONS-1:0]         i_still,
    input  wire logic [bedhv_pkg::TIME_W-1:0]   i_time,
    output logic                                o_ready,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [bedhv_pkg::BTN_W-1:0]         o_button_id,
    output logic                                o_accepted,
    output logic [bedhv_pkg::TIME_W-1:0]        o_press_time,
    output logic                                o_last_of_run
);

    logic [NUM_BUTTONS-1:0]       r_mask;
    logic [NUM_BUTTONS-1:0]       r_still;
    logic [bedhv_pkg::TIME_W-1:0] r_time;

    logic [NUM_BUTTONS-1:0] low_oh;
    logic [NUM_BUTTONS-1:0] rest;
    logic                   take;

    always_comb begin
        logic found;
        found       = 1'b0;
        low_oh      = '0;
        o_button_id = '0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (r_mask[i] && !found) begin
                found       = 1'b1;
                low_oh[i]   = 1'b1;
                o_button_id = bedhv_pkg::BTN_W'(i);
            end
        end
    end

    assign rest          = r_mask & ~low_oh;
    assign o_out_valid   = |r_mask;
    assign o_accepted    = |(r_still & low_oh);
    assign o_press_time  = r_time;
    assign o_last_of_run = (rest == '0);
    assign take          = o_out_valid && !i_out_stall;
    assign o_ready       = !o_out_valid || (take && o_last_of_run);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_load) begin
            r_mask <= i_mask;
        end else if (take) begin
            r_mask <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_still <= i_still;
            r_time  <= i_time;
        end
    end

endmodule

`default_nettype wire
